/* hw/rtl/mpts_pkg.sv */
// mpts_pkg: shared types, codes and constants for the multi-policy task scheduler
// used by the top level, mpts_ctrl and mpts_dp; no dependencies of its own
package mpts_pkg;

  // default table depth
  localparam int unsigned MAX_TASKS_DEF = 16;

  // fixed field widths
  localparam int unsigned TIME_W   = 24;
  localparam int unsigned QUANT_W  = 16;
  localparam int unsigned POLICY_W = 2;
  localparam int unsigned OIDX_W   = 4;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CFG_AW   = 1;
  localparam int unsigned CFG_DW   = 16;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = QUANT_W'(500);
  localparam logic [QUANT_W-1:0] SLICE_MAX     = '1;
  localparam logic [TIME_W-1:0]  TIME_MAX      = '1;

  // input opcodes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // scheduling policies
  localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
  localparam logic [POLICY_W-1:0] POL_RR   = 2'd1;
  localparam logic [POLICY_W-1:0] POL_SJF  = 2'd2;
  localparam logic [POLICY_W-1:0] POL_PSJF = 2'd3;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_POLICY  = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_QUANTUM = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [TIME_W-1:0] ready_time;
    logic [TIME_W-1:0] exec_time;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] tick_time;
    logic              running_valid;
    logic [OIDX_W-1:0] running_index;
    logic              finished_valid;
    logic [OIDX_W-1:0] finished_index;
    logic              all_done;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RETIRE,
    S_SCAN,
    S_DRAIN,
    S_EXEC
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic rd_run;
    logic retire;
    logic scan;
    logic exec;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

endpackage

/* hw/rtl/multi_policy_task_scheduler.sv */
// Multi-policy task scheduler (FIFO, round robin, SJF, preemptive SJF), top level.
// Input channel in_valid_i / in_stall_o / in_i carries clear, load and tick commands;
// output channel out_valid_o / out_stall_i / out_o carries one result per tick.
// Configuration port cfg_we_i / cfg_addr_i / cfg_wdata_i writes policy (0) and
// quantum (1); write only while the block is idle.
// Clear and load keep the sequencer idle: the next command is taken in the next cycle.
// A tick runs these steps before the next input slot is free: the accepting cycle
// reads the running task's remaining time, a retire step retires it, the scan streams
// the loaded entries through the single read port of each task ram to mark arrivals
// and find the minimum key, a drain step empties the compare stage and an exec step
// executes the tick into the result register; an empty table skips scan and drain.
// The result register frees the input side: a new command is taken while a result
// waits; a tick only stalls in its final cycle if the previous result is still held.
// Reset clears time, counters, arrived flags and sets policy FIFO and quantum 500;
// task table contents stay undefined until loaded. No clearing pass is needed.
// Depends on mpts_pkg, mpts_ctrl, mpts_dp and mpts_ram.
module multi_policy_task_scheduler
  import mpts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_o,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer
  mpts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_i.opcode),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // tables, scheduler state and result register
  mpts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

/* hw/rtl/mpts_ram.sv */
// mpts_ram: generic single write port, single read port ram with registered read
// no package dependencies
module mpts_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mpts_ctrl.sv */
// mpts_ctrl: sequencer for clear, load and tick operations
// depends on mpts_pkg for state, command and status types
module mpts_ctrl
  import mpts_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] opcode_i,
  output logic            in_stall_o,
  input  dp_stat_t        stat_i,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == S_IDLE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (accept) begin
          case (opcode_i)
            OP_CLEAR: cmd_o.clear = 1'b1;
            OP_LOAD:  cmd_o.load  = 1'b1;
            OP_TICK: begin
              cmd_o.rd_run = 1'b1;
              state_d      = S_RETIRE;
            end
            default: ;
          endcase
        end
      end
      S_RETIRE: begin
        cmd_o.retire = 1'b1;
        state_d      = stat_i.cnt_zero ? S_EXEC : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!stat_i.out_busy) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/mpts_dp.sv */
// mpts_dp: task tables, scheduler state, scan comparator and result register
// depends on mpts_pkg and mpts_ram
module mpts_dp
  import mpts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output dp_stat_t          stat_o,
  input  in_item_t          in_i,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output out_item_t         out_o
);

  localparam int unsigned TIDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_TASKS + 1);

  // configuration
  logic [POLICY_W-1:0] policy_q, policy_d;
  logic [QUANT_W-1:0]  quantum_q, quantum_d;

  // scheduler state
  logic [CNT_W-1:0]     entry_cnt_q, entry_cnt_d;
  logic [CNT_W-1:0]     done_cnt_q, done_cnt_d;
  logic [TIME_W-1:0]    time_q, time_d;
  logic                 run_valid_q, run_valid_d;
  logic [TIDX_W-1:0]    run_idx_q, run_idx_d;
  logic [QUANT_W-1:0]   slice_q, slice_d;
  logic [MAX_TASKS-1:0] arr_q, arr_d;

  // per-tick working registers
  logic [TIME_W-1:0] rem_run_q, rem_run_d;
  logic              pick_q, pick_d;
  logic              by_ready_q, by_ready_d;
  logic              fin_valid_q, fin_valid_d;
  logic [TIDX_W-1:0] fin_idx_q, fin_idx_d;
  logic [TIDX_W-1:0] scan_addr_q, scan_addr_d;
  logic              cmp_v_q, cmp_v_d;
  logic [TIDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic              best_v_q, best_v_d;
  logic [TIDX_W-1:0] best_idx_q, best_idx_d;
  logic [TIME_W-1:0] best_key_q, best_key_d;
  logic [TIME_W-1:0] best_rem_q, best_rem_d;

  // result register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  // ram ports
  logic              rdy_we, rem_we, rd_en;
  logic [TIDX_W-1:0] rdy_waddr, rem_waddr, rd_addr;
  logic [TIME_W-1:0] rdy_wdata, rem_wdata, rdy_rd, rem_rd;

  // combinational helpers
  logic              retire_hit, run_after_ret, requeue;
  logic              hit, cand;
  logic [TIME_W-1:0] key;
  logic              change, nv;
  logic [TIDX_W-1:0] nidx;
  logic [TIME_W-1:0] nrem;
  logic [QUANT_W-1:0] slice_base;
  logic [TIDX_W-1:0] load_addr;

  assign load_addr = entry_cnt_q[TIDX_W-1:0];
  assign rd_en     = cmd_i.rd_run || cmd_i.scan;
  assign rd_addr   = cmd_i.rd_run ? run_idx_q : scan_addr_q;

  mpts_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_TASKS)
  ) u_ready_ram (
    .clk_i   (clk_i),
    .we_i    (rdy_we),
    .waddr_i (rdy_waddr),
    .wdata_i (rdy_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdy_rd)
  );

  mpts_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_TASKS)
  ) u_remain_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rem_rd)
  );

  // retire and requeue decisions, valid while cmd_i.retire
  assign retire_hit    = run_valid_q && (rem_rd == '0);
  assign run_after_ret = run_valid_q && !retire_hit;
  assign requeue       = (policy_q == POL_RR) && run_after_ret && (slice_q >= quantum_q);

  // scan comparator on the entry read last cycle
  assign hit  = (rdy_rd == time_q);
  assign cand = (arr_q[cmp_idx_q] || hit) && (rem_rd != '0);
  assign key  = by_ready_q ? rdy_rd : rem_rd;

  // task switch decision, valid while cmd_i.exec
  assign change     = pick_q && best_v_q && (!run_valid_q || (best_idx_q != run_idx_q));
  assign nv         = change || run_valid_q;
  assign nidx       = change ? best_idx_q : run_idx_q;
  assign nrem       = change ? best_rem_q : rem_run_q;
  assign slice_base = change ? '0 : slice_q;

  // next state
  always_comb begin
    policy_d    = policy_q;
    quantum_d   = quantum_q;
    entry_cnt_d = entry_cnt_q;
    done_cnt_d  = done_cnt_q;
    time_d      = time_q;
    run_valid_d = run_valid_q;
    run_idx_d   = run_idx_q;
    slice_d     = slice_q;
    arr_d       = arr_q;
    rem_run_d   = rem_run_q;
    pick_d      = pick_q;
    by_ready_d  = by_ready_q;
    fin_valid_d = fin_valid_q;
    fin_idx_d   = fin_idx_q;
    scan_addr_d = scan_addr_q;
    cmp_v_d     = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    best_v_d    = best_v_q;
    best_idx_d  = best_idx_q;
    best_key_d  = best_key_q;
    best_rem_d  = best_rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    rdy_we      = 1'b0;
    rdy_waddr   = load_addr;
    rdy_wdata   = in_i.ready_time;
    rem_we      = 1'b0;
    rem_waddr   = load_addr;
    rem_wdata   = in_i.exec_time;

    // configuration writes
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_POLICY:  policy_d  = cfg_wdata_i[POLICY_W-1:0];
        CFG_QUANTUM: quantum_d = cfg_wdata_i[QUANT_W-1:0];
        default: ;
      endcase
    end

    // clear table and time
    if (cmd_i.clear) begin
      arr_d       = '0;
      entry_cnt_d = '0;
      time_d      = '0;
      run_valid_d = 1'b0;
      run_idx_d   = '0;
      slice_d     = '0;
      done_cnt_d  = '0;
    end

    // append a task unless the table is full
    if (cmd_i.load && (entry_cnt_q < CNT_W'(MAX_TASKS))) begin
      rdy_we           = 1'b1;
      rem_we           = 1'b1;
      arr_d[load_addr] = 1'b0;
      entry_cnt_d      = entry_cnt_q + CNT_W'(1);
    end

    // retire, round robin requeue, scan setup
    if (cmd_i.retire) begin
      fin_valid_d = retire_hit;
      fin_idx_d   = run_idx_q;
      run_valid_d = run_after_ret;
      if (retire_hit && (done_cnt_q < entry_cnt_q)) begin
        done_cnt_d = done_cnt_q + CNT_W'(1);
      end
      if (requeue) begin
        rdy_we    = 1'b1;
        rdy_waddr = run_idx_q;
        rdy_wdata = time_q;
        slice_d   = '0;
      end
      case (policy_q)
        POL_RR:   pick_d = !run_after_ret || requeue;
        POL_PSJF: pick_d = 1'b1;
        default:  pick_d = !run_after_ret;
      endcase
      by_ready_d  = (policy_q == POL_FIFO) || (policy_q == POL_RR);
      rem_run_d   = rem_rd;
      scan_addr_d = '0;
      best_v_d    = 1'b0;
    end

    // issue one table read per cycle
    if (cmd_i.scan) begin
      scan_addr_d = scan_addr_q + TIDX_W'(1);
      cmp_v_d     = 1'b1;
      cmp_idx_d   = scan_addr_q;
    end

    // arrival marking and running minimum
    if (cmp_v_q) begin
      arr_d[cmp_idx_q] = arr_q[cmp_idx_q] || hit;
      if (cand && (!best_v_q || (key < best_key_q))) begin
        best_v_d   = 1'b1;
        best_idx_d = cmp_idx_q;
        best_key_d = key;
        best_rem_d = rem_rd;
      end
    end

    // switch task, emit result, run one tick
    if (cmd_i.exec) begin
      run_valid_d          = nv;
      run_idx_d            = nidx;
      out_valid_d          = 1'b1;
      out_d.tick_time      = time_q;
      out_d.running_valid  = nv;
      out_d.running_index  = nv ? OIDX_W'(nidx) : '0;
      out_d.finished_valid = fin_valid_q;
      out_d.finished_index = fin_valid_q ? OIDX_W'(fin_idx_q) : '0;
      out_d.all_done       = (done_cnt_q == entry_cnt_q);
      if (change) begin
        slice_d = '0;
      end
      if (nv) begin
        if (nrem != '0) begin
          rem_we    = 1'b1;
          rem_waddr = nidx;
          rem_wdata = nrem - TIME_W'(1);
        end
        slice_d = (slice_base == SLICE_MAX) ? slice_base : slice_base + QUANT_W'(1);
      end
      if (time_q != TIME_MAX) begin
        time_d = time_q + TIME_W'(1);
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= POL_FIFO;
      quantum_q   <= QUANTUM_RESET;
      entry_cnt_q <= '0;
      done_cnt_q  <= '0;
      time_q      <= '0;
      run_valid_q <= 1'b0;
      run_idx_q   <= '0;
      slice_q     <= '0;
      arr_q       <= '0;
      pick_q      <= 1'b0;
      by_ready_q  <= 1'b0;
      fin_valid_q <= 1'b0;
      scan_addr_q <= '0;
      cmp_v_q     <= 1'b0;
      best_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      policy_q    <= policy_d;
      quantum_q   <= quantum_d;
      entry_cnt_q <= entry_cnt_d;
      done_cnt_q  <= done_cnt_d;
      time_q      <= time_d;
      run_valid_q <= run_valid_d;
      run_idx_q   <= run_idx_d;
      slice_q     <= slice_d;
      arr_q       <= arr_d;
      pick_q      <= pick_d;
      by_ready_q  <= by_ready_d;
      fin_valid_q <= fin_valid_d;
      scan_addr_q <= scan_addr_d;
      cmp_v_q     <= cmp_v_d;
      best_v_q    <= best_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_run_q  <= rem_run_d;
    fin_idx_q  <= fin_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    best_idx_q <= best_idx_d;
    best_key_q <= best_key_d;
    best_rem_q <= best_rem_d;
    out_q      <= out_d;
  end

  // status to controller
  assign stat_o.cnt_zero  = (entry_cnt_q == '0);
  assign stat_o.scan_last = ((CNT_W'(scan_addr_q) + CNT_W'(1)) == entry_cnt_q);
  assign stat_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // running task is always a loaded entry
  a_run_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q |-> (CNT_W'(run_idx_q) < entry_cnt_q))
    else $error("running index beyond loaded entries");

  // never more retirements than loaded tasks
  a_done_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_cnt_q <= entry_cnt_q)
    else $error("done count exceeds entry count");

  // scan comparator drained before the tick executes
  a_scan_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> !cmp_v_q)
    else $error("tick executed with a compare in flight");

  // best candidate always a loaded entry
  a_best_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && best_v_q) |-> (CNT_W'(best_idx_q) < entry_cnt_q))
    else $error("best candidate beyond loaded entries");

endmodule
